[sv/tbo_pkg.sv]
// Shared types, widths and constant tables for the triangle/box overlap unit.
// Used by every module of the unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tbo_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int HALF_W      = COORD_WIDTH - 1;
    localparam int VEC_W       = COORD_WIDTH + 1;
    localparam int EDGE_W      = COORD_WIDTH + 2;
    localparam int PROD_W      = EDGE_W + VEC_W;
    localparam int AXIS_W      = PROD_W + 1;
    localparam int RAD_W       = EDGE_W + HALF_W + 1;
    localparam int CMP_W       = AXIS_W + 1;
    localparam int NPROD_W     = 2 * EDGE_W;
    localparam int NORM_W      = NPROD_W + 1;
    localparam int NLO_W       = (NORM_W + 1) / 2;
    localparam int NHI_W       = NORM_W - NLO_W;
    localparam int PLO_W       = NLO_W + 1 + VEC_W;
    localparam int PHI_W       = NHI_W + VEC_W;
    localparam int SLO_W       = NLO_W + HALF_W;
    localparam int SHI_W       = NHI_W + HALF_W;
    localparam int WIDE_W      = NORM_W + VEC_W + 4;
    localparam int PIPE_DEPTH  = 8;
    localparam int NUM_EDGE    = 9;
    localparam int CFG_ADDR_W  = 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [VEC_W-1:0]       vec_t;
    typedef logic signed [EDGE_W-1:0]      edge_t;
    typedef logic        [HALF_W-1:0]      half_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HALF_X = 2'd0,
        CFG_HALF_Y = 2'd1,
        CFG_HALF_Z = 2'd2
    } cfg_idx_t;

    localparam half_t HALF_RESET = half_t'(64'd1 << FRAC_BITS);

    // Edge, box axis and the two projected vertices of each edge/axis test.
    localparam int EDGE_SEL [NUM_EDGE] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    localparam int AXIS_SEL [NUM_EDGE] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
    localparam int VA_SEL   [NUM_EDGE] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
    localparam int VB_SEL   [NUM_EDGE] = '{2, 2, 2, 2, 2, 1, 1, 1, 2};

endpackage

`default_nettype wire

[sv/tbo_prep.sv]
// Front stage: triangle vertices relative to the box centre and edge vectors.
// Depends on tbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbo_prep
    import tbo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   adv,
    input  wire coord_t ctr [3],
    input  wire coord_t pnt [3][3],
    output vec_t        v   [3][3],
    output edge_t       e   [3][3]
);

    vec_t  v_reg  [3][3];
    edge_t e_reg  [3][3];
    vec_t  v_next [3][3];
    edge_t e_next [3][3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int q = 0; q < 3; q++)
            begin
                v_next[a][q] = VEC_W'(pnt[a][q]) - VEC_W'(ctr[q]);
                // The centre cancels in an edge, so take it from the raw vertices.
                e_next[a][q] = EDGE_W'(pnt[(a + 1) % 3][q]) - EDGE_W'(pnt[a][q]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg <= v_next;
            e_reg <= e_next;
        end
    end

    assign v = v_reg;
    assign e = e_reg;

endmodule

`default_nettype wire

[sv/tbo_edge_axis.sv]
// One edge-cross-axis separating test, three register stages deep.
// Depends on tbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbo_edge_axis
    import tbo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  adv,
    input  wire edge_t e_a,
    input  wire edge_t e_b,
    input  wire vec_t  va_i,
    input  wire vec_t  va_j,
    input  wire vec_t  vb_i,
    input  wire vec_t  vb_j,
    input  wire half_t h_i,
    input  wire half_t h_j,
    output logic       sep
);

    logic [EDGE_W-1:0]              ea_mag;
    logic [EDGE_W-1:0]              eb_mag;
    logic signed [PROD_W-1:0]       ma0_reg, ma1_reg, mb0_reg, mb1_reg;
    logic [RAD_W-2:0]               r0_reg, r1_reg;
    logic signed [AXIS_W-1:0]       pa_reg, pb_reg;
    logic [RAD_W-1:0]               rad_reg;
    logic signed [CMP_W-1:0]        pa_x, pb_x, rad_x;
    logic                           sep_reg;
    logic                           sep_next;

    always_comb
    begin
        ea_mag = e_a[EDGE_W-1] ? EDGE_W'(-e_a) : EDGE_W'(e_a);
        eb_mag = e_b[EDGE_W-1] ? EDGE_W'(-e_b) : EDGE_W'(e_b);
        pa_x   = CMP_W'(pa_reg);
        pb_x   = CMP_W'(pb_reg);
        rad_x  = $signed(CMP_W'(rad_reg));
        // Separated when both projections lie strictly outside the same side.
        sep_next = ((rad_x < pa_x) && (rad_x < pb_x)) ||
                   ((pa_x < -rad_x) && (pb_x < -rad_x));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ma0_reg <= e_a * va_i;
            ma1_reg <= e_b * va_j;
            mb0_reg <= e_a * vb_i;
            mb1_reg <= e_b * vb_j;
            r0_reg  <= ea_mag * h_i;
            r1_reg  <= eb_mag * h_j;
            pa_reg  <= AXIS_W'(ma0_reg) - AXIS_W'(ma1_reg);
            pb_reg  <= AXIS_W'(mb0_reg) - AXIS_W'(mb1_reg);
            rad_reg <= RAD_W'(r0_reg) + RAD_W'(r1_reg);
            sep_reg <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

`default_nettype wire

[sv/tbo_plane.sv]
// Triangle-plane separating test, six register stages deep; the wide
// products are split into two halves of the normal. Depends on tbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbo_plane
    import tbo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  adv,
    input  wire edge_t e0 [3],
    input  wire edge_t e1 [3],
    input  wire vec_t  v0 [3],
    input  wire half_t h  [3],
    output logic       sep
);

    logic signed [NPROD_W-1:0] na_reg [3];
    logic signed [NPROD_W-1:0] nb_reg [3];
    vec_t                      v0a_reg [3];
    vec_t                      v0b_reg [3];
    logic signed [NORM_W-1:0]  n_reg  [3];
    logic [NORM_W-1:0]         nmag   [3];
    logic signed [PLO_W-1:0]   pl_reg [3];
    logic signed [PHI_W-1:0]   ph_reg [3];
    logic [SLO_W-1:0]          sl_reg [3];
    logic [SHI_W-1:0]          sh_reg [3];
    logic signed [WIDE_W-1:0]  t_reg  [3];
    logic signed [WIDE_W-1:0]  s_reg  [3];
    logic signed [WIDE_W-1:0]  d_reg;
    logic signed [WIDE_W-1:0]  sum_reg;
    logic                      sep_reg;

    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            nmag[q] = n_reg[q][NORM_W-1] ? NORM_W'(-n_reg[q]) : NORM_W'(n_reg[q]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int q = 0; q < 3; q++)
            begin
                na_reg[q]  <= e0[(q + 1) % 3] * e1[(q + 2) % 3];
                nb_reg[q]  <= e0[(q + 2) % 3] * e1[(q + 1) % 3];
                v0a_reg[q] <= v0[q];
                n_reg[q]   <= NORM_W'(na_reg[q]) - NORM_W'(nb_reg[q]);
                v0b_reg[q] <= v0a_reg[q];
                pl_reg[q]  <= $signed({1'b0, n_reg[q][NLO_W-1:0]}) * v0b_reg[q];
                ph_reg[q]  <= $signed(n_reg[q][NORM_W-1:NLO_W]) * v0b_reg[q];
                sl_reg[q]  <= nmag[q][NLO_W-1:0] * h[q];
                sh_reg[q]  <= nmag[q][NORM_W-1:NLO_W] * h[q];
                t_reg[q]   <= (WIDE_W'(ph_reg[q]) <<< NLO_W) + WIDE_W'(pl_reg[q]);
                s_reg[q]   <= $signed((WIDE_W'(sh_reg[q]) << NLO_W) + WIDE_W'(sl_reg[q]));
            end
            d_reg   <= -(t_reg[0] + t_reg[1] + t_reg[2]);
            sum_reg <= s_reg[0] + s_reg[1] + s_reg[2];
            // The box spans the offsets d - S to d + S; reject if zero lies outside.
            sep_reg <= (d_reg > sum_reg) || (d_reg < -sum_reg);
        end
    end

    assign sep = sep_reg;

endmodule

`default_nettype wire

[sv/triangle_box_overlap_unit.sv]
// Top level of the triangle/box overlap unit: stream ports, half-size
// registers, face test and result combining. Depends on tbo_pkg, tbo_prep,
// tbo_edge_axis and tbo_plane.
// Throughput one per cycle while the output is not stalled.
// A stalled output holds the whole pipeline. Reset clears all valid bits and
// sets the three half sizes to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module triangle_box_overlap_unit
    import tbo_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // center_x, center_y, center_z, vert0_x .. vert2_z, 32 bits each from bit 0
    input  wire logic [12*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // overlap in bit 0, zeros above
    output logic [7:0]                 m_axis_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [HALF_W-1:0]     cfg_wr_data
);

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  out_valid_reg;
    logic                  overlap_reg;
    half_t                 half_reg [3];
    coord_t                ctr_reg  [3];
    coord_t                pnt_reg  [3][3];
    vec_t                  v        [3][3];
    edge_t                 e        [3][3];
    logic [NUM_EDGE-1:0]   edge_sep;
    logic                  plane_sep;
    logic                  face_next;
    logic                  face_reg;
    logic                  face_d_reg;
    logic [3:0]            rej_reg;
    logic signed [VEC_W:0] hpos [3];
    logic                  all_hi;
    logic                  all_lo;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, overlap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg[0] <= HALF_RESET;
            half_reg[1] <= HALF_RESET;
            half_reg[2] <= HALF_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_HALF_X: half_reg[0] <= cfg_wr_data;
                CFG_HALF_Y: half_reg[1] <= cfg_wr_data;
                CFG_HALF_Z: half_reg[2] <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int q = 0; q < 3; q++)
            begin
                ctr_reg[q] <= s_axis_tdata[q*COORD_WIDTH +: COORD_WIDTH];
                for (int a = 0; a < 3; a++)
                begin
                    pnt_reg[a][q] <= s_axis_tdata[(3 + 3*a + q)*COORD_WIDTH +: COORD_WIDTH];
                end
            end
        end
    end

    tbo_prep u_prep
    (
        .clk (clk),
        .adv (adv),
        .ctr (ctr_reg),
        .pnt (pnt_reg),
        .v   (v),
        .e   (e)
    );

    for (genvar g = 0; g < NUM_EDGE; g++)
    begin : g_edge
        localparam int K  = AXIS_SEL[g];
        localparam int I  = (K + 1) % 3;
        localparam int J  = (K + 2) % 3;
        localparam int EI = EDGE_SEL[g];
        localparam int A  = VA_SEL[g];
        localparam int B  = VB_SEL[g];

        tbo_edge_axis u_edge
        (
            .clk  (clk),
            .adv  (adv),
            .e_a  (e[EI][J]),
            .e_b  (e[EI][I]),
            .va_i (v[A][I]),
            .va_j (v[A][J]),
            .vb_i (v[B][I]),
            .vb_j (v[B][J]),
            .h_i  (half_reg[I]),
            .h_j  (half_reg[J]),
            .sep  (edge_sep[g])
        );
    end

    tbo_plane u_plane
    (
        .clk (clk),
        .adv (adv),
        .e0  (e[0]),
        .e1  (e[1]),
        .v0  (v[0]),
        .h   (half_reg),
        .sep (plane_sep)
    );

    // Box face test: every vertex strictly beyond the same face of the box.
    always_comb
    begin
        face_next = 1'b0;
        for (int q = 0; q < 3; q++)
        begin
            hpos[q] = $signed({3'b000, half_reg[q]});
            all_hi  = 1'b1;
            all_lo  = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                all_hi = all_hi && ((VEC_W+1)'(v[a][q]) > hpos[q]);
                all_lo = all_lo && ((VEC_W+1)'(v[a][q]) < -hpos[q]);
            end
            face_next = face_next || all_hi || all_lo;
        end
    end

    // The face result passes through face_reg, face_d_reg and rej_reg[0] so that it meets
    // the edge tests of the same transaction, and the sum then meets the plane test.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            face_reg    <= face_next;
            face_d_reg  <= face_reg;
            rej_reg     <= {rej_reg[2:1], rej_reg[0] || (|edge_sep), face_d_reg};
            overlap_reg <= !(rej_reg[3] || plane_sep);
        end
    end

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the output is stalled");

    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (vld_reg[PIPE_DEPTH-1:1] == $past(vld_reg[PIPE_DEPTH-2:0])))
        else $error("valid bits did not advance with the pipeline");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vld_reg) && $stable(out_valid_reg)))
        else $error("valid bits moved during a stall");

endmodule

`default_nettype wire
